// ----- rtl/ssi_pkg.sv -----
`default_nettype none
package ssi_pkg;

	// which point of the segment the test used
	typedef enum logic [1:0] {
		REGION_START    = 2'd0,
		REGION_INTERIOR = 2'd1,
		REGION_END      = 2'd2
	} region_t;

	// per-request control carried beside the wide multipliers
	typedef struct packed {
		logic    hit;
		region_t region;
		logic    a_neg;
	} ssi_side_t;

endpackage
`default_nettype wire

// ----- rtl/ssi_if.sv -----
`default_nettype none
interface ssi_req_if #(
	parameter int COORD_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] start_z;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] end_z;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic        [COORD_BITS-2:0] radius;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		       center_x, center_y, center_z, radius,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
		       center_x, center_y, center_z, radius,
		output ready
	);
endinterface

interface ssi_rsp_if;
	logic            valid;
	logic            ready;
	logic            hit;
	ssi_pkg::region_t region;

	modport source (output valid, hit, region, input ready);
	modport sink (input valid, hit, region, output ready);
endinterface
`default_nettype wire

// ----- rtl/segment_sphere_intersect.sv -----
`default_nettype none
// Segment/sphere proximity test. Each request carries a segment (start, end),
// a sphere centre and a radius in signed fixed point with 8 fraction bits; the
// response says whether the segment point closest to the centre lies within or
// on the sphere, and whether that point is the start clamp, an interior point or
// the end clamp. A zero-length segment is tested as its start point. The test is
// exact: no division, no rounding. The block is a 7-stage pipeline (differences,
// coordinate products, dot sums, region decision, two stages of split wide
// multiply for the interior test |w|^2*L - D^2 <= r^2*L, final compare into the
// output register). It takes one request per clock while req.ready is high;
// when the response is not taken the whole pipeline holds and req.ready drops.
module segment_sphere_intersect #(
	parameter int COORD_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ssi_req_if.sink   req,
	ssi_rsp_if.source rsp
);
	localparam int N  = COORD_BITS;
	localparam int U  = 2*N + 2;   // unsigned squares and nonnegative dot products
	localparam int SW = 2*N + 4;   // signed dot sums

	logic en;

	logic signed [N-1:0] st [3];
	logic signed [N-1:0] ed [3];
	logic signed [N-1:0] ce [3];

	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [N:0]   d_s1 [3];
	logic signed [N:0]   w_s1 [3];
	logic signed [N:0]   c_s1 [3];
	logic        [N-2:0] r_s1;

	logic signed [2*N+1:0] pdd_s2 [3];
	logic signed [2*N+1:0] pdw_s2 [3];
	logic signed [2*N+1:0] pww_s2 [3];
	logic signed [2*N+1:0] pvv_s2 [3];
	logic        [2*N-3:0] pr2_s2;

	logic signed [SW-1:0] len2_s3, proj_s3, ww_s3, vv_s3;
	logic        [U-1:0]  r2_s3;

	logic                 proj_neg, len_zero, beyond_end;
	logic        [U-1:0]  len2_u, proj_u, ww_u, vv_u;
	ssi_pkg::ssi_side_t   side_c, side_s4, side_s5, side_s6;
	logic        [U-1:0]  l_s4, dd_s4, au_s4;

	logic        [2*U-1:0] p_al, p_dd;
	logic                  hit_s7;
	ssi_pkg::region_t      region_s7;

	assign en        = !v_s7 || rsp.ready;
	assign req.ready = en;

	always_comb begin
		st[0] = req.start_x;  st[1] = req.start_y;  st[2] = req.start_z;
		ed[0] = req.end_x;    ed[1] = req.end_y;    ed[2] = req.end_z;
		ce[0] = req.center_x; ce[1] = req.center_y; ce[2] = req.center_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stages 1 to 3: differences, products, dot sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]   <= (N+1)'(ed[k]) - (N+1)'(st[k]);
				w_s1[k]   <= (N+1)'(ce[k]) - (N+1)'(st[k]);
				c_s1[k]   <= (N+1)'(ce[k]) - (N+1)'(ed[k]);
				pdd_s2[k] <= d_s1[k] * d_s1[k];
				pdw_s2[k] <= d_s1[k] * w_s1[k];
				pww_s2[k] <= w_s1[k] * w_s1[k];
				pvv_s2[k] <= c_s1[k] * c_s1[k];
			end
			r_s1    <= req.radius;
			pr2_s2  <= r_s1 * r_s1;
			len2_s3 <= SW'(pdd_s2[0]) + SW'(pdd_s2[1]) + SW'(pdd_s2[2]);
			proj_s3 <= SW'(pdw_s2[0]) + SW'(pdw_s2[1]) + SW'(pdw_s2[2]);
			ww_s3   <= SW'(pww_s2[0]) + SW'(pww_s2[1]) + SW'(pww_s2[2]);
			vv_s3   <= SW'(pvv_s2[0]) + SW'(pvv_s2[1]) + SW'(pvv_s2[2]);
			r2_s3   <= U'(pr2_s2);
		end
	end

	// stage 4: clamp region and the endpoint distance tests
	always_comb begin
		len2_u     = len2_s3[U-1:0];
		proj_u     = proj_s3[U-1:0];
		ww_u       = ww_s3[U-1:0];
		vv_u       = vv_s3[U-1:0];
		proj_neg   = proj_s3[SW-1];
		len_zero   = (len2_u == '0);
		beyond_end = len2_u < proj_u;
		side_c.a_neg = ww_u < r2_s3;
		if (len_zero || proj_neg) begin
			side_c.region = ssi_pkg::REGION_START;
			side_c.hit    = ww_u <= r2_s3;
		end else if (beyond_end) begin
			side_c.region = ssi_pkg::REGION_END;
			side_c.hit    = vv_u <= r2_s3;
		end else begin
			side_c.region = ssi_pkg::REGION_INTERIOR;
			side_c.hit    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_c;
			l_s4    <= len2_u;
			dd_s4   <= proj_u;
			au_s4   <= ww_u - r2_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	// stages 5 and 6: (|w|^2 - r^2) * L against D^2
	ssi_wmul #(.W(U)) u_mul_al (
		.clk (clk),
		.en  (en),
		.a   (au_s4),
		.b   (l_s4),
		.p   (p_al)
	);

	ssi_wmul #(.W(U)) u_mul_dd (
		.clk (clk),
		.en  (en),
		.a   (dd_s4),
		.b   (dd_s4),
		.p   (p_dd)
	);

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (en) begin
			region_s7 <= side_s6.region;
			if (side_s6.region == ssi_pkg::REGION_INTERIOR) begin
				hit_s7 <= side_s6.a_neg || (p_al <= p_dd);
			end else begin
				hit_s7 <= side_s6.hit;
			end
		end
	end

	assign rsp.valid  = v_s7;
	assign rsp.hit    = hit_s7;
	assign rsp.region = region_s7;
endmodule
`default_nettype wire

// ----- rtl/ssi_wmul.sv -----
`default_nettype none
// two-stage unsigned multiplier built from four half-width partial products
module ssi_wmul #(
	parameter int W = 42
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic      [2*W-1:0] p
);
	localparam int H = W / 2;
	localparam int L = W - H;

	logic [2*L-1:0]   pp_ll_s1;
	logic [L+H-1:0]   pp_lh_s1;
	logic [L+H-1:0]   pp_hl_s1;
	logic [2*H-1:0]   pp_hh_s1;
	logic [2*W-1:0]   p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a[L-1:0] * b[L-1:0];
			pp_lh_s1 <= a[L-1:0] * b[W-1:L];
			pp_hl_s1 <= a[W-1:L] * b[L-1:0];
			pp_hh_s1 <= a[W-1:L] * b[W-1:L];
			p_s2     <= (2*W)'(pp_ll_s1)
			          + ((2*W)'(pp_lh_s1) << L)
			          + ((2*W)'(pp_hl_s1) << L)
			          + ((2*W)'(pp_hh_s1) << (2*L));
		end
	end

	assign p = p_s2;
endmodule
`default_nettype wire

// ----- rtl/ssi_checker.sv -----
`default_nettype none
module ssi_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire logic             hit,
	input wire ssi_pkg::region_t region
);
	logic idle_go;

	assign idle_go = !(req_valid && req_ready) && rsp_ready;

	// a held response keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(region))
		else $error("response changed while stalled");

	// the pipeline only refuses a request when its output is backed up
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("request refused with output free");

	// with no new request and a free output the pipeline drains
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		idle_go ##1 idle_go ##1 idle_go ##1 idle_go ##1 idle_go ##1 idle_go
		##1 idle_go |=> !rsp_valid)
		else $error("response without a request");
endmodule

bind segment_sphere_intersect ssi_checker u_ssi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.hit       (rsp.hit),
	.region    (rsp.region)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

	localparam int CB = 20;
	localparam int MN = -524288;
	localparam int MX = 524287;
	localparam int RM = 524287;
	localparam int N_DIR = 19;
	localparam int N_RAND = 550;
	localparam int CALM_ITEMS = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [CB-1:0] start_x, start_y, start_z;
		logic signed [CB-1:0] end_x, end_y, end_z;
		logic signed [CB-1:0] center_x, center_y, center_z;
		logic        [CB-2:0] radius;
	} seg_req_t;

	typedef struct packed {
		logic             hit;
		ssi_pkg::region_t region;
	} seg_rsp_t;

	// typed = 1: hit and region below are the known answer, else use the predictor
	typedef struct {
		int sx, sy, sz, ex, ey, ez, cx, cy, cz, r;
		int typed, hit, region;
	} dir_row_t;

	dir_row_t dir_tab [N_DIR] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, ssi_pkg::REGION_START},
		'{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0, ssi_pkg::REGION_START},
		'{MN, MN, MN, MX, MX, MX, MN, MN, MN, RM, 1, 1, ssi_pkg::REGION_INTERIOR},
		'{MN, MN, MN, MX, MX, MX, MX, MX, MX, 0, 1, 1, ssi_pkg::REGION_INTERIOR},
		'{0, 0, 0, 256, 0, 0, 512, 0, 0, 256, 1, 1, ssi_pkg::REGION_END},
		'{0, 0, 0, 256, 0, 0, 512, 0, 0, 255, 1, 0, ssi_pkg::REGION_END},
		'{0, 0, 0, 256, 0, 0, -256, 0, 0, 256, 1, 1, ssi_pkg::REGION_START},
		'{0, 0, 0, 256, 0, 0, -256, 0, 0, 255, 1, 0, ssi_pkg::REGION_START},
		'{0, 0, 0, 512, 0, 0, 256, 256, 0, 256, 1, 1, ssi_pkg::REGION_INTERIOR},
		'{0, 0, 0, 512, 0, 0, 256, 256, 0, 255, 1, 0, ssi_pkg::REGION_INTERIOR},
		'{MN, MN, MN, MN, MN, MN, MX, MX, MX, RM, 1, 0, ssi_pkg::REGION_START},
		'{MX, MX, MX, MX, MX, MX, MX, MX, MX, 0, 1, 1, ssi_pkg::REGION_START},
		'{MX, MX, MX, MN, MN, MN, 0, 0, 0, 0, 0, 0, ssi_pkg::REGION_START},
		'{-1000, 2000, -3000, 4000, -5000, 6000, 100, -200, 300, 3000, 0, 0,
			ssi_pkg::REGION_START},
		'{MX, MN, MX, MN, MX, MN, MN, MN, MX, RM, 0, 0, ssi_pkg::REGION_START},
		'{-1, -1, -1, 0, 0, 0, -1, -1, -1, 0, 1, 1, ssi_pkg::REGION_INTERIOR},
		'{100, 100, 100, 300, 100, 100, 301, 100, 100, 1, 1, 1, ssi_pkg::REGION_END},
		'{100, 100, 100, 300, 100, 100, 99, 100, 100, 0, 1, 0, ssi_pkg::REGION_START},
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 174762, 1, 1, ssi_pkg::REGION_START}
	};

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   mismatch_cnt = 0;
	int   idle_cycles = 0;

	seg_rsp_t pending_rsp [$];
	seg_rsp_t rsp_want;

	ssi_req_if #(.COORD_BITS(CB)) seg_req ();
	ssi_rsp_if seg_rsp ();

	segment_sphere_intersect #(.COORD_BITS(CB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seg_req.sink),
		.rsp    (seg_rsp.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// exact closest-point test, 128 bits is far wider than any intermediate
	function automatic seg_rsp_t closest_point_test(seg_req_t q);
		logic signed [127:0] dx, dy, dz, wx, wy, wz, vx, vy, vz;
		logic signed [127:0] len2, proj, ww, vv, r2;
		seg_rsp_t res;
		dx = 128'(q.end_x) - 128'(q.start_x);
		dy = 128'(q.end_y) - 128'(q.start_y);
		dz = 128'(q.end_z) - 128'(q.start_z);
		wx = 128'(q.center_x) - 128'(q.start_x);
		wy = 128'(q.center_y) - 128'(q.start_y);
		wz = 128'(q.center_z) - 128'(q.start_z);
		vx = 128'(q.center_x) - 128'(q.end_x);
		vy = 128'(q.center_y) - 128'(q.end_y);
		vz = 128'(q.center_z) - 128'(q.end_z);
		r2 = 128'(q.radius) * 128'(q.radius);
		len2 = dx * dx + dy * dy + dz * dz;
		proj = dx * wx + dy * wy + dz * wz;
		ww = wx * wx + wy * wy + wz * wz;
		vv = vx * vx + vy * vy + vz * vz;
		if (len2 == 0 || proj < 0) begin
			res.region = ssi_pkg::REGION_START;
			res.hit = (ww <= r2);
		end else if (proj > len2) begin
			res.region = ssi_pkg::REGION_END;
			res.hit = (vv <= r2);
		end else begin
			res.region = ssi_pkg::REGION_INTERIOR;
			res.hit = (ww * len2 - proj * proj <= r2 * len2);
		end
		return res;
	endfunction

	function automatic int rnd_span(int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	// mostly segments with the centre placed near them, the rest raw bits
	function automatic seg_req_t rand_request();
		seg_req_t q;
		int s [3];
		int e [3];
		int c [3];
		int mode, lim, ofs, tn, k;
		mode = int'($urandom_range(9));
		if (mode < 2) begin
			q.start_x = CB'($urandom);
			q.start_y = CB'($urandom);
			q.start_z = CB'($urandom);
			q.end_x = CB'($urandom);
			q.end_y = CB'($urandom);
			q.end_z = CB'($urandom);
			q.center_x = CB'($urandom);
			q.center_y = CB'($urandom);
			q.center_z = CB'($urandom);
			q.radius = (CB-1)'($urandom);
		end else begin
			lim = ($urandom_range(3) == 0) ? 100000 : 2000;
			ofs = 1 << $urandom_range(16);
			tn = int'($urandom_range(1600)) - 300;
			for (k = 0; k < 3; k++) begin
				s[k] = rnd_span(lim);
				// zero-length segment now and then
				e[k] = (mode == 2) ? s[k] : rnd_span(lim);
				c[k] = s[k] + ((e[k] - s[k]) * tn) / 1000 + rnd_span(ofs);
			end
			q.start_x = CB'(s[0]);
			q.start_y = CB'(s[1]);
			q.start_z = CB'(s[2]);
			q.end_x = CB'(e[0]);
			q.end_y = CB'(e[1]);
			q.end_z = CB'(e[2]);
			q.center_x = CB'(c[0]);
			q.center_y = CB'(c[1]);
			q.center_z = CB'(c[2]);
			q.radius = (CB-1)'($urandom_range(2 * ofs));
		end
		return q;
	endfunction

	task automatic send_request(seg_req_t q, bit typed, seg_rsp_t known);
		if (!calm && $urandom_range(5) == 0) begin
			seg_req.valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		seg_req.start_x <= q.start_x;
		seg_req.start_y <= q.start_y;
		seg_req.start_z <= q.start_z;
		seg_req.end_x <= q.end_x;
		seg_req.end_y <= q.end_y;
		seg_req.end_z <= q.end_z;
		seg_req.center_x <= q.center_x;
		seg_req.center_y <= q.center_y;
		seg_req.center_z <= q.center_z;
		seg_req.radius <= q.radius;
		seg_req.valid <= 1'b1;
		do @(posedge clk); while (!seg_req.ready);
		pending_rsp.push_back(typed ? known : closest_point_test(q));
	endtask

	task automatic drain_responses();
		seg_req.valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
	endtask

	initial begin
		seg_req_t q;
		seg_rsp_t known;
		int i;
		arst_n <= 1'b0;
		seg_req.valid <= 1'b0;
		seg_req.start_x <= '0;
		seg_req.start_y <= '0;
		seg_req.start_z <= '0;
		seg_req.end_x <= '0;
		seg_req.end_y <= '0;
		seg_req.end_z <= '0;
		seg_req.center_x <= '0;
		seg_req.center_y <= '0;
		seg_req.center_z <= '0;
		seg_req.radius <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < N_DIR; i++) begin
			q.start_x = CB'(dir_tab[i].sx);
			q.start_y = CB'(dir_tab[i].sy);
			q.start_z = CB'(dir_tab[i].sz);
			q.end_x = CB'(dir_tab[i].ex);
			q.end_y = CB'(dir_tab[i].ey);
			q.end_z = CB'(dir_tab[i].ez);
			q.center_x = CB'(dir_tab[i].cx);
			q.center_y = CB'(dir_tab[i].cy);
			q.center_z = CB'(dir_tab[i].cz);
			q.radius = (CB-1)'(dir_tab[i].r);
			known.hit = dir_tab[i].hit[0];
			known.region = ssi_pkg::region_t'(dir_tab[i].region[1:0]);
			send_request(q, dir_tab[i].typed != 0, known);
		end
		drain_responses();
		for (i = 0; i < N_RAND; i++) begin
			if (i == N_RAND / 2)
				drain_responses();
			if (i == N_RAND - CALM_ITEMS)
				calm = 1'b1;
			send_request(rand_request(), 1'b0, known);
		end
		drain_responses();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// response side: random stall bursts until the calm tail
	initial begin
		int stall_left;
		stall_left = 0;
		seg_rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && !calm && $urandom_range(11) == 0)
				stall_left = $urandom_range(13, 1);
			if (stall_left != 0) begin
				seg_rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				seg_rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && seg_rsp.valid && seg_rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with no request outstanding, hit %0b region %0d",
					$time, seg_rsp.hit, seg_rsp.region);
				mismatch_cnt++;
			end else begin
				rsp_want = pending_rsp.pop_front();
				if (seg_rsp.hit !== rsp_want.hit) begin
					$display("%0t: hit mismatch, expected %0b, actual %0b",
						$time, rsp_want.hit, seg_rsp.hit);
					mismatch_cnt++;
				end
				if (seg_rsp.region !== rsp_want.region) begin
					$display("%0t: region mismatch, expected %0d, actual %0d",
						$time, rsp_want.region, seg_rsp.region);
					mismatch_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((seg_req.valid && seg_req.ready) || (seg_rsp.valid && seg_rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

endmodule

// ----- segment_sphere_intersect.f -----
rtl/ssi_pkg.sv
rtl/ssi_if.sv
rtl/ssi_wmul.sv
rtl/segment_sphere_intersect.sv
rtl/ssi_checker.sv
tb/sv/tb_top.sv
